// File: src/lrtcam_pkg.sv
// constants and helpers shared by the ram-based ternary cam
package lrtcam_pkg;

  localparam int LUT_ADDR_BITS = 5;
  localparam int LUT_DATA_BITS = 16;
  localparam int ENTRIES       = 64;
  localparam int KEY_BITS      = 20;

  localparam int NUM_CHUNKS = KEY_BITS / LUT_ADDR_BITS;
  localparam int NUM_GROUPS = ENTRIES / LUT_DATA_BITS;
  localparam int NUM_LUTS   = NUM_CHUNKS * NUM_GROUPS;
  localparam int LUT_DEPTH  = 1 << LUT_ADDR_BITS;
  localparam int MATCH_BITS = NUM_GROUPS * LUT_DATA_BITS;

  localparam int SEL_BITS   = 4;
  localparam int WORD_BITS  = 16;
  localparam int INDEX_BITS = 6;

  localparam logic OP_SEARCH = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  typedef logic [LUT_ADDR_BITS-1:0] lut_addr_t;
  typedef logic [LUT_DATA_BITS-1:0] lut_data_t;
  typedef logic [KEY_BITS-1:0]      key_t;
  typedef logic [MATCH_BITS-1:0]    match_vec_t;
  typedef logic [INDEX_BITS-1:0]    match_index_t;

  // chunk c of the key addresses the rams of that chunk
  function automatic lut_addr_t key_chunk(input key_t key, input int c);
    key_chunk = key[c*LUT_ADDR_BITS +: LUT_ADDR_BITS];
  endfunction

  // lowest set bit of the match vector, masked to the index width
  function automatic match_index_t lowest_match(input match_vec_t m);
    match_index_t idx;
    idx = '0;
    for (int i = MATCH_BITS - 1; i >= 0; i--) begin
      if (m[i]) begin
        idx = INDEX_BITS'(i);
      end
    end
    lowest_match = idx;
  endfunction

endpackage

// File: src/lrtcam_req_if.sv
// request channel of the cam: search or ram update
interface lrtcam_req_if;
  import lrtcam_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 operation;
  logic [KEY_BITS-1:0]  search_key;
  logic [SEL_BITS-1:0]  lut_select;
  logic [WORD_BITS-1:0] lut_word;

  modport source (
    output valid, operation, search_key, lut_select, lut_word,
    input  ready
  );
  modport sink (
    input  valid, operation, search_key, lut_select, lut_word,
    output ready
  );
endinterface

// File: src/lrtcam_rsp_if.sv
// response channel of the cam: search result
interface lrtcam_rsp_if;
  import lrtcam_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  hit;
  logic [INDEX_BITS-1:0] match_index;

  modport source (
    output valid, hit, match_index,
    input  ready
  );
  modport sink (
    input  valid, hit, match_index,
    output ready
  );
endinterface

// File: src/lut_ram_tcam_search.sv
// ternary cam built from small lookup rams, top level
//
//  channel  dir  payload                                         handshake
//  req      in   operation, search_key, lut_select, lut_word     valid/ready
//  rsp      out  hit, match_index (one per search, none/update)  valid/ready
//
// an item is taken every cycle while no clearing pass runs and rsp is not
// stalled; a search result is offered on rsp after the registered read of
// the lookup rams and the output register.
// after reset a clearing pass zeroes all rams one row a cycle, all LUT_DEPTH
// rows (32 with the defaults), while req.ready stays low.
// the read stage holds while the output register waits, so a stalled rsp
// backs up to req one stage later.
module lut_ram_tcam_search
  import lrtcam_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  lrtcam_req_if.sink    req,
  lrtcam_rsp_if.source  rsp
);

  lut_data_t    lut_mem [NUM_LUTS][LUT_DEPTH];
  lut_data_t    rd_data [NUM_LUTS];

  logic         clr_busy;
  lut_addr_t    clr_addr;
  logic         s1_valid;
  logic         out_valid;
  logic         hit;
  match_index_t match_index;

  logic         s1_move;
  logic         in_acc;
  logic         search_acc;
  logic         update_acc;
  match_vec_t   match_vec;

  assign s1_move    = s1_valid && (!out_valid || rsp.ready);
  assign req.ready  = !clr_busy && (!s1_valid || s1_move);
  assign in_acc     = req.valid && req.ready;
  assign search_acc = in_acc && (req.operation == OP_SEARCH);
  assign update_acc = in_acc && (req.operation == OP_UPDATE);

  // lookup rams: one write port for clear or update, one read port each
  always_ff @(posedge clk) begin
    for (int r = 0; r < NUM_LUTS; r++) begin
      if (clr_busy) begin
        lut_mem[r][clr_addr] <= '0;
      end else if (update_acc && (int'(req.lut_select) == r)) begin
        lut_mem[r][key_chunk(req.search_key, r % NUM_CHUNKS)] <=
          req.lut_word[LUT_DATA_BITS-1:0];
      end
      if (search_acc) begin
        rd_data[r] <= lut_mem[r][key_chunk(req.search_key, r % NUM_CHUNKS)];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == lut_addr_t'(LUT_DEPTH - 1)) begin
        clr_busy <= 1'b0;
      end
    end
  end

  // and the words of each group, group 0 in the low bits
  always_comb begin
    lut_data_t grp;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      grp = '1;
      for (int c = 0; c < NUM_CHUNKS; c++) begin
        grp = grp & rd_data[g*NUM_CHUNKS + c];
      end
      match_vec[g*LUT_DATA_BITS +: LUT_DATA_BITS] = grp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (search_acc) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      hit         <= |match_vec;
      match_index <= lowest_match(match_vec);
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.hit         = hit;
  assign rsp.match_index = match_index;

  a_no_accept_while_clearing: assert property (
    @(posedge clk) clr_busy |-> !req.ready
  ) else $error("item taken during clearing pass");

  a_search_reaches_read_stage: assert property (
    @(posedge clk) disable iff (rst) search_acc |=> s1_valid
  ) else $error("accepted search lost before read stage");

  a_read_stage_drains: assert property (
    @(posedge clk) disable iff (rst) (s1_valid && !out_valid) |=> out_valid
  ) else $error("read stage did not move to output");

  a_miss_index_zero: assert property (
    @(posedge clk) disable iff (rst) (rsp.valid && !rsp.hit) |-> (rsp.match_index == '0)
  ) else $error("miss with non-zero index");

endmodule
